// ----- hw/rtl/nse_pkg.sv -----
// Shared types and constants of the Nash-Sutcliffe efficiency block.
package nse_pkg;

    // Operation of the shared adder.
    typedef enum logic {
        OP_ADD = 1'b0,
        OP_SUB = 1'b1
    } op_t;

    localparam int FRAC_BITS = 16;
    localparam int NSE_W     = 32;
    // Quotient register: one bit more than the widest value that still gives a result.
    localparam int Q_W       = 33;

    localparam logic [Q_W-1:0]   Q_ONE      = 33'h0_0001_0000;
    localparam logic [Q_W-1:0]   CLIP_LIMIT = 33'h0_8001_0000;
    localparam logic [NSE_W-1:0] NSE_MIN    = 32'h8000_0000;

endpackage

// ----- hw/rtl/nse_addsub.sv -----
// Shared adder/subtractor used by the arithmetic steps of the sequencer.
module nse_addsub #(
    parameter int W = 68
) (
    input  nse_pkg::op_t   op,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic [W-1:0]   sum,
    output logic           carry
);

    logic [W-1:0] b_eff;
    logic [W:0]   full;

    assign b_eff = (op == nse_pkg::OP_SUB) ? ~b : b;
    // On a subtract the carry out is high exactly when a >= b.
    assign full  = {1'b0, a} + {1'b0, b_eff} + (W+1)'(op == nse_pkg::OP_SUB);
    assign sum   = full[W-1:0];
    assign carry = full[W];

endmodule

// ----- hw/rtl/nash_sutcliffe_efficiency.sv -----
// Top level of the Nash-Sutcliffe efficiency accumulator with its sequencer.
//
//   channel | ports                                          | direction
//   --------+------------------------------------------------+----------
//   s_      | s_valid s_ready s_sim_value s_obs_value s_last_pair | in
//   m_      | m_valid m_ready m_nse_value m_zero_spread m_clipped | out
//
// An accumulated pair passes through S_SQO, S_SQE and S_ADDE: the squaring multiplier and the one shared
// adder update the three sums one after the other.
// A last pair adds the end-of-series work: shift-add products on the shared adder,
// a subtract on it and a zero check for the denominator, NUMW + 16 restoring division
// steps on the shared adder and a final load of the result.
// Reset (aresetn low at a clock edge) clears the sums at once; there is no clearing pass.
// The result waits in an output register; new items are taken meanwhile, and only the
// next series end waits for that register to empty.
module nash_sutcliffe_efficiency #(
    parameter int MAX_PAIRS   = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sim_value,
    input  logic signed [SAMPLE_BITS-1:0] s_obs_value,
    input  logic                          s_last_pair,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [nse_pkg::NSE_W-1:0] m_nse_value,
    output logic                          m_zero_spread,
    output logic                          m_clipped
);

    localparam int SB     = SAMPLE_BITS;
    localparam int CW     = $clog2(MAX_PAIRS + 1);
    localparam int SOW    = SB + CW;
    localparam int OSQW   = 2 * SB + CW;
    localparam int ESQW   = 2 * SB + 1 + CW;
    localparam int NUMW   = ESQW + CW;
    localparam int DENW   = OSQW + CW;
    localparam int W      = NUMW + 1;
    localparam int PW     = 2 * SB + 2;
    localparam int MPW    = SOW;
    localparam int DSTEPS = NUMW + nse_pkg::FRAC_BITS;
    localparam int DCW    = $clog2(DSTEPS + 1);
    localparam int QW     = nse_pkg::Q_W;

    localparam logic [CW-1:0]  MAX_CNT  = CW'(MAX_PAIRS);
    localparam logic [DCW-1:0] DIV_LAST = DCW'(DSTEPS - 1);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_SQO   = 11'b000_0000_0010,
        S_SQE   = 11'b000_0000_0100,
        S_ADDE  = 11'b000_0000_1000,
        S_MNUM  = 11'b000_0001_0000,
        S_MDEN1 = 11'b000_0010_0000,
        S_MDEN2 = 11'b000_0100_0000,
        S_SUB   = 11'b000_1000_0000,
        S_CHK   = 11'b001_0000_0000,
        S_DIV   = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [SOW-1:0]      so_reg, so_next;
    logic [OSQW-1:0]     osq_reg, osq_next;
    logic [ESQW-1:0]     esq_reg, esq_next;
    logic [SB-1:0]       o_reg, o_next;
    logic [SB-1:0]       omag_reg, omag_next;
    logic [SB:0]         dmag_reg, dmag_next;
    logic                last_reg, last_next;
    logic [PW-1:0]       prod_reg, prod_next;
    logic [W-1:0]        acc_reg, acc_next;
    logic [W-1:0]        mcand_reg, mcand_next;
    logic [MPW-1:0]      mplier_reg, mplier_next;
    logic [NUMW-1:0]     num_reg, num_next;
    logic [DENW-1:0]     den_reg, den_next;
    logic [DENW-1:0]     rem_reg, rem_next;
    logic [QW-1:0]       q_reg, q_next;
    logic                big_reg, big_next;
    logic [DCW-1:0]      dcnt_reg, dcnt_next;
    logic                zero_reg, zero_next;
    logic                m_valid_reg, m_valid_next;
    logic [nse_pkg::NSE_W-1:0] nse_reg, nse_next;
    logic                zs_reg, zs_next;
    logic                clip_reg, clip_next;

    nse_pkg::op_t        add_op;
    logic [W-1:0]        add_a, add_b, add_sum;
    logic                add_carry;

    logic [SB-1:0]       s_u, o_u;
    logic [SB:0]         diff;
    logic [SB:0]         mul_x;
    logic [SOW-1:0]      so_mag;
    logic [DENW:0]       trial;
    logic                in_acc, out_load, clip_now;

    nse_addsub #(.W(W)) u_addsub (
        .op    (add_op),
        .a     (add_a),
        .b     (add_b),
        .sum   (add_sum),
        .carry (add_carry)
    );

    assign s_u    = s_sim_value;
    assign o_u    = s_obs_value;
    assign diff   = {s_u[SB-1], s_u} - {o_u[SB-1], o_u};
    assign so_mag = so_reg[SOW-1] ? (~so_reg + SOW'(1)) : so_reg;
    assign trial  = {rem_reg, num_reg[NUMW-1]};
    assign in_acc = s_valid && s_ready;
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    assign clip_now = !zero_reg && (big_reg || (q_reg > nse_pkg::CLIP_LIMIT));

    // The squaring multiplier takes the observation first, then the error.
    assign mul_x = (state_reg == S_SQO) ? {1'b0, omag_reg} : dmag_reg;

    always_comb begin
        add_op = nse_pkg::OP_ADD;
        add_a  = '0;
        add_b  = '0;
        case (state_reg)
            S_SQO: begin
                add_a = {{(W-SOW){so_reg[SOW-1]}}, so_reg};
                add_b = {{(W-SB){o_reg[SB-1]}}, o_reg};
            end
            S_SQE: begin
                add_a = W'(osq_reg);
                add_b = W'(prod_reg);
            end
            S_ADDE: begin
                add_a = W'(esq_reg);
                add_b = W'(prod_reg);
            end
            S_MNUM, S_MDEN1, S_MDEN2: begin
                add_a = acc_reg;
                add_b = mcand_reg;
            end
            S_SUB: begin
                add_op = nse_pkg::OP_SUB;
                add_a  = W'(den_reg);
                add_b  = acc_reg;
            end
            S_DIV: begin
                add_op = nse_pkg::OP_SUB;
                add_a  = W'(trial);
                add_b  = W'(den_reg);
            end
            default: begin
                add_op = nse_pkg::OP_ADD;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        so_next      = so_reg;
        osq_next     = osq_reg;
        esq_next     = esq_reg;
        o_next       = o_reg;
        omag_next    = omag_reg;
        dmag_next    = dmag_reg;
        last_next    = last_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        q_next       = q_reg;
        big_next     = big_reg;
        dcnt_next    = dcnt_reg;
        zero_next    = zero_reg;
        nse_next     = nse_reg;
        zs_next      = zs_reg;
        clip_next    = clip_reg;
        m_valid_next = m_valid_reg && !m_ready;

        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    last_next = s_last_pair;
                    if (cnt_reg < MAX_CNT) begin
                        cnt_next   = cnt_reg + CW'(1);
                        o_next     = o_u;
                        omag_next  = o_u[SB-1] ? (~o_u + SB'(1)) : o_u;
                        dmag_next  = diff[SB] ? (~diff + (SB+1)'(1)) : diff;
                        state_next = S_SQO;
                    end else if (s_last_pair) begin
                        // Count is full: the pair is dropped but still ends the series.
                        acc_next    = '0;
                        mcand_next  = W'(esq_reg);
                        mplier_next = MPW'(cnt_reg);
                        state_next  = S_MNUM;
                    end
                end
            end
            S_SQO: begin
                prod_next  = mul_x * mul_x;
                so_next    = add_sum[SOW-1:0];
                state_next = S_SQE;
            end
            S_SQE: begin
                prod_next  = mul_x * mul_x;
                osq_next   = add_sum[OSQW-1:0];
                state_next = S_ADDE;
            end
            S_ADDE: begin
                esq_next = add_sum[ESQW-1:0];
                if (last_reg) begin
                    acc_next    = '0;
                    mcand_next  = W'(add_sum[ESQW-1:0]);
                    mplier_next = MPW'(cnt_reg);
                    state_next  = S_MNUM;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_MNUM, S_MDEN1, S_MDEN2: begin
                if (mplier_reg == '0) begin
                    acc_next = '0;
                    if (state_reg == S_MNUM) begin
                        num_next    = acc_reg[NUMW-1:0];
                        mcand_next  = W'(osq_reg);
                        mplier_next = MPW'(cnt_reg);
                        state_next  = S_MDEN1;
                    end else if (state_reg == S_MDEN1) begin
                        den_next    = acc_reg[DENW-1:0];
                        mcand_next  = W'(so_mag);
                        mplier_next = so_mag;
                        state_next  = S_MDEN2;
                    end else begin
                        // The square of the observation sum stays in acc for the subtract.
                        acc_next   = acc_reg;
                        state_next = S_SUB;
                    end
                end else begin
                    if (mplier_reg[0]) begin
                        acc_next = add_sum;
                    end
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                end
            end
            S_SUB: begin
                den_next   = add_sum[DENW-1:0];
                state_next = S_CHK;
            end
            S_CHK: begin
                rem_next  = '0;
                q_next    = '0;
                big_next  = 1'b0;
                dcnt_next = '0;
                if (den_reg == '0) begin
                    zero_next  = 1'b1;
                    state_next = S_DONE;
                end else begin
                    zero_next  = 1'b0;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                // One restoring step; the numerator shifts out MSB first, then zeros
                // supply the sixteen fraction bits.
                rem_next  = add_carry ? add_sum[DENW-1:0] : trial[DENW-1:0];
                q_next    = {q_reg[QW-2:0], add_carry};
                big_next  = big_reg | q_reg[QW-1];
                num_next  = num_reg << 1;
                dcnt_next = dcnt_reg + DCW'(1);
                if (dcnt_reg == DIV_LAST) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    zs_next      = zero_reg;
                    clip_next    = clip_now;
                    if (zero_reg) begin
                        nse_next = '0;
                    end else if (clip_now) begin
                        nse_next = nse_pkg::NSE_MIN;
                    end else begin
                        nse_next = nse_pkg::NSE_W'(nse_pkg::Q_ONE - q_reg);
                    end
                    cnt_next   = '0;
                    so_next    = '0;
                    osq_next   = '0;
                    esq_next   = '0;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            so_reg      <= '0;
            osq_reg     <= '0;
            esq_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            so_reg      <= so_next;
            osq_reg     <= osq_next;
            esq_reg     <= esq_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        o_reg      <= o_next;
        omag_reg   <= omag_next;
        dmag_reg   <= dmag_next;
        last_reg   <= last_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        big_reg    <= big_next;
        dcnt_reg   <= dcnt_next;
        zero_reg   <= zero_next;
        nse_reg    <= nse_next;
        zs_reg     <= zs_next;
        clip_reg   <= clip_next;
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_nse_value   = nse_reg;
    assign m_zero_spread = zs_reg;
    assign m_clipped     = clip_reg;

`ifndef SYNTH
    // The product of the count and the square sum can never fall below the squared sum.
    a_den_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SUB) |-> add_carry)
        else $error("denominator went negative");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (rem_reg < den_reg))
        else $error("division remainder not below divisor");

    a_clear_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (cnt_reg == '0 && so_reg == '0 && osq_reg == '0 && esq_reg == '0))
        else $error("sums not cleared after a result");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= MAX_CNT)
        else $error("pair count beyond its limit");
`endif

endmodule
